### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/etmc_pkg.sv
// types and constants of the encoder motion controller
`timescale 1ns / 1ps

package etmc_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int CNT_OUT_W      = 24;
  localparam int REG_W          = 16;
  localparam int POWER_W        = 8;
  localparam int DRIVE_W        = 9;
  localparam int DEG_W          = 9;
  localparam int DIST_W         = 18;
  localparam int IDX_W          = 3;
  localparam int ROT_PROD_W     = REG_W + DEG_W;
  localparam int GOAL_W         = REG_W + DIST_W;
  localparam int IN_DATA_W      = 32;
  localparam int IN_USER_W      = 2;
  localparam int OUT_DATA_W     = 72;

  localparam int ROT_DIV        = 90;
  localparam int MOVE_SCALE     = 25600;
  localparam int MOVE_TOL       = 2;

  localparam logic [REG_W-1:0]   ROT90_L_RST = 16'd841;
  localparam logic [REG_W-1:0]   ROT90_R_RST = 16'd830;
  localparam logic [REG_W-1:0]   PPU_L_RST   = 16'd29576;
  localparam logic [REG_W-1:0]   PPU_R_RST   = 16'd29902;
  localparam logic [POWER_W-1:0] POWER_RST   = 8'd128;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ROTATE = 2'd1,
    REQ_MOVE   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_DONE      = 2'd1,
    ST_REFUSED   = 2'd2,
    ST_DONE_OBST = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_FWD    = 2'd2,
    MODE_BACK   = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_L = 3'd0,
    REG_ROT_R = 3'd1,
    REG_PPU_L = 3'd2,
    REG_PPU_R = 3'd3,
    REG_POWER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    req_t                     req;
    logic                     edge_left;
    logic                     edge_right;
    logic                     manual_mode;
    logic                     obstacle;
    logic                     turn_right;
    logic [DEG_W-1:0]         degrees;
    logic signed [DIST_W-1:0] distance;
  } item_t;

  typedef struct packed {
    logic [REG_W-1:0]   rot90_left;
    logic [REG_W-1:0]   rot90_right;
    logic [REG_W-1:0]   ppu_left;
    logic [REG_W-1:0]   ppu_right;
    logic [POWER_W-1:0] power;
  } cfg_t;

  // first member sits in the high bits, so the order is reversed here
  typedef struct packed {
    logic [CNT_OUT_W-1:0]      right_count;
    logic [CNT_OUT_W-1:0]      left_count;
    status_t                   status;
    logic                      busy_res;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
  } result_t;

  localparam int OUT_PAD = OUT_DATA_W - $bits(result_t);

endpackage

### src/etmc_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module etmc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [etmc_pkg::IDX_W-1:0]     wr_index,
  input  logic [etmc_pkg::REG_W-1:0]     wr_data,
  output etmc_pkg::cfg_t                 cfg_o
);

  etmc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot90_left  <= etmc_pkg::ROT90_L_RST;
      cfg_r.rot90_right <= etmc_pkg::ROT90_R_RST;
      cfg_r.ppu_left    <= etmc_pkg::PPU_L_RST;
      cfg_r.ppu_right   <= etmc_pkg::PPU_R_RST;
      cfg_r.power       <= etmc_pkg::POWER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        etmc_pkg::REG_ROT_L: cfg_r.rot90_left  <= wr_data;
        etmc_pkg::REG_ROT_R: cfg_r.rot90_right <= wr_data;
        etmc_pkg::REG_PPU_L: cfg_r.ppu_left    <= wr_data;
        etmc_pkg::REG_PPU_R: cfg_r.ppu_right   <= wr_data;
        etmc_pkg::REG_POWER: cfg_r.power       <= wr_data[etmc_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

### src/etmc_in_reg.sv
// input register stage of the controller
`timescale 1ns / 1ps

module etmc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  etmc_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            advance,
  output logic            item_vld_o,
  output etmc_pkg::item_t item_o
);

  logic            vld_r;
  etmc_pkg::item_t item_r;

  assign in_ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld_o = vld_r;
  assign item_o     = item_r;

endmodule

### src/etmc_core.sv
// motion state, goal checks and result register
`timescale 1ns / 1ps

module etmc_core #(
  parameter int COUNT_BITS = etmc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  etmc_pkg::item_t   item,
  input  etmc_pkg::cfg_t    cfg,
  output logic              advance,
  output logic              out_vld_o,
  input  logic              out_ready,
  output etmc_pkg::result_t res_o
);

  localparam int CMP_W = (COUNT_BITS + 15 > etmc_pkg::GOAL_W) ?
                         COUNT_BITS + 15 : etmc_pkg::GOAL_W;
  localparam int EXT_W = (COUNT_BITS > etmc_pkg::CNT_OUT_W) ?
                         COUNT_BITS : etmc_pkg::CNT_OUT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]         cnt_l_r, cnt_r_r, cnt_l_nxt, cnt_r_nxt;
  logic [etmc_pkg::GOAL_W-1:0]   goal_l_r, goal_r_r, goal_l_nxt, goal_r_nxt;
  logic [1:0]                    act_r, act_nxt;
  logic [1:0]                    signs_r, signs_nxt;
  etmc_pkg::mode_t               mode_r, mode_nxt;
  logic                          out_vld_r;
  etmc_pkg::result_t             res_r, res_nxt;

  logic                          step;
  logic                          tick_l, tick_r;
  logic [etmc_pkg::DIST_W-1:0]   dist_u, mag, span;
  logic                          neg;
  logic [etmc_pkg::GOAL_W-1:0]   rot_goal_l, rot_goal_r, mv_goal_l, mv_goal_r;
  etmc_pkg::mode_t               mode_pre;
  logic [1:0]                    act_pre, act_run, reached;
  etmc_pkg::status_t             status_pre, status_nxt;
  logic [CMP_W-1:0]              sc_l, sc_r, gl_ext, gr_ext;
  logic [etmc_pkg::DRIVE_W-1:0]  pwr_pos, pwr_neg;
  logic [EXT_W-1:0]              cnt_l_ext, cnt_r_ext;

  assign advance = !out_vld_r || out_ready;
  assign step    = item_vld && advance;

  // counter update
  always_comb begin
    tick_l = (item.req == etmc_pkg::REQ_TICK) && !item.manual_mode &&
             item.edge_left && (cnt_l_r != CNT_MAX);
    tick_r = (item.req == etmc_pkg::REQ_TICK) && !item.manual_mode &&
             item.edge_right && (cnt_r_r != CNT_MAX);
    if (item.req == etmc_pkg::REQ_CLEAR) begin
      cnt_l_nxt = '0;
      cnt_r_nxt = '0;
    end else begin
      cnt_l_nxt = cnt_l_r + COUNT_BITS'(tick_l);
      cnt_r_nxt = cnt_r_r + COUNT_BITS'(tick_r);
    end
  end

  // goals for a new command
  always_comb begin
    dist_u = item.distance;
    neg    = dist_u[etmc_pkg::DIST_W-1];
    mag    = neg ? (~dist_u + etmc_pkg::DIST_W'(1)) : dist_u;
    span   = (mag >= etmc_pkg::DIST_W'(etmc_pkg::MOVE_TOL)) ?
             mag - etmc_pkg::DIST_W'(etmc_pkg::MOVE_TOL) : '0;
    rot_goal_l = etmc_pkg::GOAL_W'(etmc_pkg::ROT_PROD_W'(cfg.rot90_left) *
                                   etmc_pkg::ROT_PROD_W'(item.degrees));
    rot_goal_r = etmc_pkg::GOAL_W'(etmc_pkg::ROT_PROD_W'(cfg.rot90_right) *
                                   etmc_pkg::ROT_PROD_W'(item.degrees));
    mv_goal_l  = etmc_pkg::GOAL_W'(span) * etmc_pkg::GOAL_W'(cfg.ppu_left);
    mv_goal_r  = etmc_pkg::GOAL_W'(span) * etmc_pkg::GOAL_W'(cfg.ppu_right);
  end

  // state after the command part of the item
  always_comb begin
    mode_pre   = mode_r;
    act_pre    = act_r;
    signs_nxt  = signs_r;
    goal_l_nxt = goal_l_r;
    goal_r_nxt = goal_r_r;
    status_pre = etmc_pkg::ST_NONE;
    unique case (item.req)
      etmc_pkg::REQ_ROTATE: begin
        mode_pre   = etmc_pkg::MODE_ROTATE;
        act_pre    = 2'b11;
        signs_nxt  = item.turn_right ? 2'b10 : 2'b01;
        goal_l_nxt = rot_goal_l;
        goal_r_nxt = rot_goal_r;
      end
      etmc_pkg::REQ_MOVE: begin
        priority if (mag == '0) begin
          mode_pre   = etmc_pkg::MODE_IDLE;
          act_pre    = 2'b00;
          signs_nxt  = 2'b00;
          status_pre = item.obstacle ? etmc_pkg::ST_DONE_OBST : etmc_pkg::ST_DONE;
        end else if (!neg && item.obstacle) begin
          mode_pre   = etmc_pkg::MODE_IDLE;
          act_pre    = 2'b00;
          signs_nxt  = 2'b00;
          status_pre = etmc_pkg::ST_REFUSED;
        end else begin
          mode_pre   = neg ? etmc_pkg::MODE_BACK : etmc_pkg::MODE_FWD;
          act_pre    = 2'b11;
          signs_nxt  = neg ? 2'b11 : 2'b00;
          goal_l_nxt = mv_goal_l;
          goal_r_nxt = mv_goal_r;
        end
      end
      default: ;
    endcase
  end

  // goal checks: rotation floor(p/90) <= c is the same as p <= 90c + 89
  always_comb begin
    gl_ext = CMP_W'(goal_l_nxt);
    gr_ext = CMP_W'(goal_r_nxt);
    if (mode_pre == etmc_pkg::MODE_ROTATE) begin
      sc_l = CMP_W'(cnt_l_nxt) * CMP_W'(etmc_pkg::ROT_DIV) + CMP_W'(etmc_pkg::ROT_DIV - 1);
      sc_r = CMP_W'(cnt_r_nxt) * CMP_W'(etmc_pkg::ROT_DIV) + CMP_W'(etmc_pkg::ROT_DIV - 1);
    end else begin
      sc_l = CMP_W'(cnt_l_nxt) * CMP_W'(etmc_pkg::MOVE_SCALE);
      sc_r = CMP_W'(cnt_r_nxt) * CMP_W'(etmc_pkg::MOVE_SCALE);
    end
    reached = {sc_r >= gr_ext, sc_l >= gl_ext};
  end

  always_comb begin
    mode_nxt   = mode_pre;
    act_run    = act_pre;
    act_nxt    = act_pre;
    status_nxt = status_pre;
    if (mode_pre != etmc_pkg::MODE_IDLE) begin
      if (mode_pre == etmc_pkg::MODE_FWD && item.obstacle) begin
        act_run = 2'b00;
      end
      act_nxt = act_run & ~reached;
      if (act_nxt == 2'b00) begin
        status_nxt = (mode_pre != etmc_pkg::MODE_ROTATE && item.obstacle) ?
                     etmc_pkg::ST_DONE_OBST : etmc_pkg::ST_DONE;
        mode_nxt   = etmc_pkg::MODE_IDLE;
      end
    end
  end

  // result fields
  always_comb begin
    pwr_pos   = etmc_pkg::DRIVE_W'(cfg.power);
    pwr_neg   = ~pwr_pos + etmc_pkg::DRIVE_W'(1);
    cnt_l_ext = EXT_W'(cnt_l_nxt);
    cnt_r_ext = EXT_W'(cnt_r_nxt);
    res_nxt.left_drive  = !act_nxt[0] ? '0 :
                          ((signs_nxt[0] && mode_nxt != etmc_pkg::MODE_IDLE) ?
                           pwr_neg : pwr_pos);
    res_nxt.right_drive = !act_nxt[1] ? '0 :
                          ((signs_nxt[1] && mode_nxt != etmc_pkg::MODE_IDLE) ?
                           pwr_neg : pwr_pos);
    res_nxt.busy_res    = (mode_nxt != etmc_pkg::MODE_IDLE);
    res_nxt.status      = status_nxt;
    res_nxt.left_count  = cnt_l_ext[etmc_pkg::CNT_OUT_W-1:0];
    res_nxt.right_count = cnt_r_ext[etmc_pkg::CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_l_r   <= '0;
      cnt_r_r   <= '0;
      act_r     <= 2'b00;
      signs_r   <= 2'b00;
      mode_r    <= etmc_pkg::MODE_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        cnt_l_r   <= cnt_l_nxt;
        cnt_r_r   <= cnt_r_nxt;
        act_r     <= act_nxt;
        signs_r   <= (mode_nxt == etmc_pkg::MODE_IDLE) ? 2'b00 : signs_nxt;
        mode_r    <= mode_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      goal_l_r <= goal_l_nxt;
      goal_r_r <= goal_r_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_vld_o = out_vld_r;
  assign res_o     = res_r;

endmodule

### src/encoder_target_motion_controller_top.sv
// an item passes the input register and then the result register before its result is valid
// throughput: one item per cycle while out_tready is high, set by the input and result registers
// a stalled result holds the pipe, one more item waits in the input register
// reset: synchronous, active low; clears counters, motion state and both
// stages, and loads the configuration registers with their defaults
`timescale 1ns / 1ps

`include "assert_macros.svh"

module encoder_target_motion_controller_top #(
  parameter int COUNT_BITS = etmc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // edge_left, edge_right, manual_mode, obstacle, turn_right, degrees, distance
  input  logic [etmc_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  logic [etmc_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // left_drive, right_drive, busy_res, status, left_count, right_count, pad
  output logic [etmc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [etmc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [etmc_pkg::REG_W-1:0]         cfg_data
);

  etmc_pkg::item_t   in_item, item;
  etmc_pkg::cfg_t    cfg;
  etmc_pkg::result_t res;
  logic              item_vld;
  logic              advance;

  always_comb begin
    in_item.req         = etmc_pkg::req_t'(in_tuser);
    in_item.edge_left   = in_tdata[0];
    in_item.edge_right  = in_tdata[1];
    in_item.manual_mode = in_tdata[2];
    in_item.obstacle    = in_tdata[3];
    in_item.turn_right  = in_tdata[4];
    in_item.degrees     = in_tdata[13:5];
    in_item.distance    = in_tdata[31:14];
  end

  assign cfg_ready = 1'b1;

  etmc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  etmc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .in_ready   (in_tready),
    .advance    (advance),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  etmc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .cfg       (cfg),
    .advance   (advance),
    .out_vld_o (out_tvalid),
    .out_ready (out_tready),
    .res_o     (res)
  );

  assign out_tdata = {{etmc_pkg::OUT_PAD{1'b0}}, res};

  `ASSERT_IMPL(a_idle_no_drive, out_tvalid && !res.busy_res, res.left_drive == '0 && res.right_drive == '0)
  `ASSERT_IMPL(a_end_not_busy, out_tvalid && res.status != etmc_pkg::ST_NONE, !res.busy_res)
  `ASSERT_IMPL(a_full_stall, item_vld && out_tvalid && !out_tready, !in_tready)
  `ASSERT_NEXT(a_item_drains, item_vld && !out_tvalid, out_tvalid)

endmodule
